[design/gps_reply_frame_parser_assert.svh]
// Assertion macros shared by the reply frame parser modules.
// The clocked form samples on clk and is held off while arst_n is low.
// The raw form has no reset qualifier and is meant for checks that must
// hold during reset as well.
`ifndef GPS_REPLY_FRAME_PARSER_ASSERT_SVH
`define GPS_REPLY_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define GRFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GRFP_ASSERT_RAW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRFP_ASSERT(lbl, prop, msg)
`define GRFP_ASSERT_RAW(lbl, prop, msg)
`endif

`endif

[design/gpsrfp_pkg.sv]
`timescale 1ns / 1ps
package gpsrfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hA0;
	localparam logic [7:0] SYNC_SECOND = 8'hA1;
	localparam logic [7:0] ID_ACK      = 8'h83;
	localparam logic [7:0] ID_NACK     = 8'h84;

	localparam logic [1:0] REP_ACK   = 2'd0;
	localparam logic [1:0] REP_NACK  = 2'd1;
	localparam logic [1:0] REP_BYTE  = 2'd2;
	localparam logic [1:0] REP_EMPTY = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One result item as it travels from the parser to the output queue.
	typedef struct packed {
		logic [1:0] report;
		logic [7:0] payload_byte;
		logic [7:0] message_id;
		logic       last;
	} result_t;

endpackage

[design/gpsrfp_front.sv]
`timescale 1ns / 1ps
`include "gps_reply_frame_parser_assert.svh"
module gpsrfp_front
	import gpsrfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic       expects_reply,
	output logic       push,
	output result_t    res
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SYNC1 = 7'b0000010,
		ST_SYNC2 = 7'b0000100,
		ST_LENHI = 7'b0001000,
		ST_LENLO = 7'b0010000,
		ST_ID    = 7'b0100000,
		ST_DATA  = 7'b1000000
	} state_t;

	state_t      state_q, state_d;
	logic [15:0] rem_q, rem_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [7:0]  id_q, id_d;
	logic        exp_q, exp_d;
	logic        accept;
	logic [15:0] rem_dec;

	assign accept  = in_valid && in_ready;
	assign rem_dec = rem_q - 16'd1;

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		lenhi_d = lenhi_q;
		id_d    = id_q;
		exp_d   = exp_q;
		push    = 1'b0;
		res     = '{report: REP_BYTE, payload_byte: 8'd0, message_id: id_q, last: 1'b1};
		if (accept) begin
			if (kind) begin
				// A new command drops any frame in progress and restarts the hunt.
				state_d = ST_SYNC1;
				exp_d   = expects_reply;
				rem_d   = 16'd0;
				lenhi_d = 8'd0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
					end
					ST_SYNC1: begin
						if (rx_byte == SYNC_FIRST) begin
							state_d = ST_SYNC2;
						end
					end
					ST_SYNC2: begin
						if (rx_byte == SYNC_SECOND) begin
							state_d = ST_LENHI;
						end else if (rx_byte != SYNC_FIRST) begin
							state_d = ST_SYNC1;
						end
					end
					ST_LENHI: begin
						lenhi_d = rx_byte;
						state_d = ST_LENLO;
					end
					ST_LENLO: begin
						rem_d   = {lenhi_q, rx_byte};
						state_d = ST_ID;
					end
					ST_ID: begin
						id_d           = rx_byte;
						rem_d          = rem_dec;
						res.message_id = rx_byte;
						if (rx_byte == ID_ACK) begin
							if (exp_q) begin
								state_d = ST_SYNC1;
							end else begin
								state_d    = ST_IDLE;
								push       = 1'b1;
								res.report = REP_ACK;
							end
						end else if (rx_byte == ID_NACK) begin
							state_d    = ST_IDLE;
							push       = 1'b1;
							res.report = REP_NACK;
						end else if (rem_dec == 16'd0) begin
							state_d    = ST_IDLE;
							push       = 1'b1;
							res.report = REP_EMPTY;
						end else begin
							state_d = ST_DATA;
						end
					end
					ST_DATA: begin
						push             = 1'b1;
						res.payload_byte = rx_byte;
						if (rem_q == 16'd0 || rem_q == 16'd1) begin
							rem_d   = 16'd0;
							state_d = ST_IDLE;
						end else begin
							rem_d    = rem_dec;
							res.last = 1'b0;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= 16'd0;
			lenhi_q <= 8'd0;
			id_q    <= 8'd0;
			exp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			lenhi_q <= lenhi_d;
			id_q    <= id_d;
			exp_q   <= exp_d;
		end
	end

	`GRFP_ASSERT(a_push_only_on_byte, push |-> (accept && !kind), "result without an accepted byte")
	`GRFP_ASSERT(a_arm_to_hunt, (accept && kind) |=> (state_q == ST_SYNC1), "arming did not restart the hunt")
	`GRFP_ASSERT(a_data_always_emits, (accept && !kind && state_q == ST_DATA) |-> push, "payload byte dropped")

endmodule

[design/gpsrfp_queue.sv]
`timescale 1ns / 1ps
`include "gps_reply_frame_parser_assert.svh"
module gpsrfp_queue
	import gpsrfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    not_full,
	output logic    pop_valid,
	input  logic    pop_ready,
	output result_t pop_data
);

	result_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                wr_en;
	logic                rd_en;

	assign not_full  = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];
	assign wr_en     = push && not_full;
	assign rd_en     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`GRFP_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
	`GRFP_ASSERT(a_ptr_gap, (QPTR_W'(wr_ptr_q - rd_ptr_q)) == QPTR_W'(cnt_q), "pointers disagree with count")
	`GRFP_ASSERT(a_no_push_when_full, push |-> not_full, "result pushed into a full queue")

endmodule

[design/gps_reply_frame_parser.sv]
`timescale 1ns / 1ps
// Channel   Direction  Transaction carries
// s_*       in         one received UART byte or one command-issued notice
// m_*       out        one parser report (ack, nack, payload byte, empty reply)
//
// Each accepted input transaction is parsed in the cycle it is taken, so a new
// byte can be accepted every cycle; the one-byte-per-cycle frame state machine
// in the front part sets that rate. Reports wait in a four-entry queue; a
// stalled output side only stops input once that queue is full. Input ready
// depends on the registered queue fill alone, not on m_tready. Reset is
// asynchronous and leaves the parser idle and unarmed with an empty queue.
module gps_reply_frame_parser
	import gpsrfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] rx_byte, [8] expects_reply, [15:9] zero
	input  logic [0:0]  s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] payload_byte, [15:8] message_id
	output logic [1:0]  m_tuser,  // [1:0] report
	output logic        m_tlast
);

	logic    push;
	logic    not_full;
	result_t front_res;
	result_t queue_res;

	// The front part classifies each byte against the frame layout and raises a
	// report when one is due. It is paced only by room in the queue.
	gpsrfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (not_full),
		.kind         (s_tuser[0]),
		.rx_byte      (s_tdata[7:0]),
		.expects_reply(s_tdata[8]),
		.push         (push),
		.res          (front_res)
	);

	// The queue decouples the parser from the consumer so that either side can
	// stall without holding up the other until it fills.
	gpsrfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(front_res),
		.not_full (not_full),
		.pop_valid(m_tvalid),
		.pop_ready(m_tready),
		.pop_data (queue_res)
	);

	assign s_tready = not_full;
	assign m_tdata  = {queue_res.message_id, queue_res.payload_byte};
	assign m_tuser  = queue_res.report;
	assign m_tlast  = queue_res.last;

endmodule

[verif/gps_reply_frame_parser_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the reply frame parser. It predicts the reports
// from the accepted input transactions and compares each accepted output
// transaction with the oldest prediction.
module gps_reply_frame_parser_checker
	import gpsrfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] rx_byte, [8] expects_reply, [15:9] zero
	input  logic [0:0]  s_tuser,  // [0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // [7:0] payload_byte, [15:8] message_id
	input  logic [1:0]  m_tuser,  // [1:0] report
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending,
	output int          reports_checked
);

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_SYNC1,
		PARSE_SYNC2,
		PARSE_LENHI,
		PARSE_LENLO,
		PARSE_ID,
		PARSE_DATA
	} parse_phase_t;

	parse_phase_t phase;
	logic [15:0]  remaining;
	logic [7:0]   len_high;
	logic [7:0]   frame_id;
	logic         reply_pending;
	result_t      expected_reports[$];

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Advances the predicted parser by one input transaction and queues the
	// report it causes, if any.
	task automatic predict_parse(input logic kind, input logic [7:0] rx, input logic want_reply);
		result_t r;
		logic    emit;
		r = '0;
		emit = 1'b0;
		if (kind) begin
			phase = PARSE_SYNC1;
			reply_pending = want_reply;
			remaining = '0;
			len_high = '0;
		end else begin
			case (phase)
				PARSE_SYNC1: begin
					if (rx == SYNC_FIRST)
						phase = PARSE_SYNC2;
				end
				PARSE_SYNC2: begin
					if (rx == SYNC_SECOND)
						phase = PARSE_LENHI;
					else if (rx != SYNC_FIRST)
						phase = PARSE_SYNC1;
				end
				PARSE_LENHI: begin
					len_high = rx;
					phase = PARSE_LENLO;
				end
				PARSE_LENLO: begin
					remaining = {len_high, rx};
					phase = PARSE_ID;
				end
				PARSE_ID: begin
					frame_id = rx;
					remaining = remaining - 16'd1;
					r.last = 1'b1;
					if (rx == ID_ACK) begin
						if (reply_pending) begin
							phase = PARSE_SYNC1;
						end else begin
							phase = PARSE_IDLE;
							r.report = REP_ACK;
							emit = 1'b1;
						end
					end else if (rx == ID_NACK) begin
						phase = PARSE_IDLE;
						r.report = REP_NACK;
						emit = 1'b1;
					end else if (remaining == 16'd0) begin
						phase = PARSE_IDLE;
						r.report = REP_EMPTY;
						emit = 1'b1;
					end else begin
						phase = PARSE_DATA;
					end
				end
				PARSE_DATA: begin
					r.report = REP_BYTE;
					r.payload_byte = rx;
					r.last = (remaining <= 16'd1);
					remaining = remaining - 16'd1;
					emit = 1'b1;
					if (r.last) begin
						remaining = '0;
						phase = PARSE_IDLE;
					end
				end
				default: phase = PARSE_IDLE;
			endcase
		end
		if (emit) begin
			r.message_id = frame_id;
			expected_reports.push_back(r);
		end
	endtask

	task automatic check_report();
		result_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("report %0d id %02h arrived with nothing expected",
				m_tuser, m_tdata[15:8]));
			return;
		end
		want = expected_reports.pop_front();
		if (m_tuser !== want.report)
			report_mismatch($sformatf("report %0d, expected %0d", m_tuser, want.report));
		if (m_tdata[7:0] !== want.payload_byte)
			report_mismatch($sformatf("payload byte %02h, expected %02h",
				m_tdata[7:0], want.payload_byte));
		if (m_tdata[15:8] !== want.message_id)
			report_mismatch($sformatf("message id %02h, expected %02h",
				m_tdata[15:8], want.message_id));
		if (m_tlast !== want.last)
			report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
		reports_checked++;
	endtask

	// The input side is handled first so that a report leaving in the same
	// cycle as its cause would still find its expectation queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase <= PARSE_IDLE;
			remaining <= '0;
			len_high <= '0;
			frame_id <= '0;
			reply_pending <= 1'b0;
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_parse(s_tuser[0], s_tdata[7:0], s_tdata[8]);
			if (m_tvalid && m_tready)
				check_report();
			pending <= expected_reports.size();
		end
	end

endmodule

[verif/tb_gps_reply_frame_parser.sv]
`timescale 1ns / 1ps
// Top of the reply frame parser testbench. It makes the stimulus, paces both
// sides of the block, and gives the verdict; the checker beside the block does
// all prediction and comparison.
module tb_gps_reply_frame_parser;
	import gpsrfp_pkg::*;

	// Cycles with no transaction on either side before the run is called hung.
	// The slowest legal stretch is a full output queue behind a slow receiver,
	// which still keeps moving.
	localparam int IDLE_LIMIT = 2000;
	// This margin catches any stray report that shows up after the last
	// expected one.
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 1050;
	// Passed as the cut point when a frame is to be sent in full.
	localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;

	// Receiver pacing modes, switched at random by the pacing block below.
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_MASK,
		READY_SLOW,
		READY_RANDOM
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [7:0] rx_byte, [8] expects_reply, [15:9] zero
	logic [0:0]  s_tuser = '0;  // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // [7:0] payload_byte, [15:8] message_id
	logic [1:0]  m_tuser;       // [1:0] report
	logic        m_tlast;

	int mismatches;
	int pending;
	int reports_checked;
	int items_sent = 0;
	int frames_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	sink_mode_t sink_mode = READY_ALWAYS;
	logic [7:0] sink_mask = 8'hFF;
	logic [7:0] sink_cycle = '0;

	gps_reply_frame_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	gps_reply_frame_parser_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.pending         (pending),
		.reports_checked (reports_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver pacing. Each stretch picks a mode at random: always ready, a
	// repeating byte-wide mask, a sparse pattern keyed to the cycle count, or a coin toss per cycle.
	// The mask always keeps one bit set so the receiver never stalls forever.
	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 8'd1;
		if (sink_cycle[6:0] == 7'd0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			sink_mask <= 8'($urandom) | 8'h01;
		end
		case (sink_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_MASK:   m_tready <= sink_mask[sink_cycle[2:0]];
			READY_SLOW:   m_tready <= (sink_cycle % 6 == 0);
			default:      m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Watchdog: a run in which neither side moves for too long is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Drives one input transaction and returns at the edge that accepts it.
	// The sender works in bursts, and tvalid drops between bursts.
	// Burst and gap lengths are random, and a quarter of the bursts
	// follow the previous one with no gap at all. Must be called at a rising
	// edge; valid stays high from one transaction to the next inside a burst.
	task automatic send_item(input logic kind, input logic [7:0] rx, input logic want_reply);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, want_reply, rx};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	// A received byte; the reply flag travels at random since the parser
	// must ignore it on bytes.
	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b, 1'($urandom_range(0, 1)));
	endtask

	// A command-issued notice; its byte field carries garbage on purpose.
	task automatic arm(input logic want_reply);
		send_item(1'b1, 8'($urandom), want_reply);
	endtask

	// Sends a reply frame: sync pair, big-endian length, message ID, n
	// payload bytes, then checksum and the CR LF trailer. The length field is
	// n + 1 in 16 bits, so n = 65535 puts a zero in it. Only the first `cut`
	// bytes go out, which gives truncated frames.
	task automatic send_frame(input logic [7:0] id, input int unsigned n,
	                          input int unsigned cut);
		logic [15:0] len;
		logic [7:0]  b;
		len = 16'(n + 1);
		for (int unsigned i = 0; i < n + 8 && i < cut; i++) begin
			if (i == 0)
				b = SYNC_FIRST;
			else if (i == 1)
				b = SYNC_SECOND;
			else if (i == 2)
				b = len[15:8];
			else if (i == 3)
				b = len[7:0];
			else if (i == 4)
				b = id;
			else if (i < n + 5)
				b = 8'($urandom);
			else if (i == n + 5)
				b = 8'($urandom);
			else if (i == n + 6)
				b = 8'h0D;
			else
				b = 8'h0A;
			send_byte(b);
		end
		frames_sent++;
	endtask

	// Payload size for a random reply: mostly short, some empty, a few
	// medium, and now and then one that needs a nonzero high length byte.
	function automatic int unsigned pick_payload_size();
		int unsigned roll;
		roll = $urandom_range(0, 199);
		if (roll < 10)
			return 0;
		if (roll < 192)
			return $urandom_range(1, 12);
		if (roll < 199)
			return $urandom_range(13, 64);
		return $urandom_range(256, 300);
	endfunction

	initial begin
		int unsigned roll;
		int unsigned pick;
		logic        want_reply;
		logic [7:0]  id;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A byte before any command is ignored, reply flag set or not.
		send_item(1'b0, SYNC_FIRST, 1'b1);

		// Command with a reply after its ACK. The hunt first sees a sync byte
		// followed by junk, then two sync bytes in a row before the second one.
		// The ACK frame produces nothing; the reply frame is a NACK.
		arm(1'b1);
		send_byte(SYNC_FIRST);
		send_byte(8'h5A);
		send_byte(SYNC_FIRST);
		send_frame(ID_ACK, 0, 5);
		send_frame(ID_NACK, 0, 5);

		// Length field of zero wraps to a huge payload. Stream the two byte
		// extremes without the last flag, then re-arm in the middle of it.
		arm(1'b0);
		send_frame(8'hFF, 65535, 5);
		send_byte(8'h00);
		send_byte(8'hFF);

		// Length of one: an empty reply, here with message ID zero.
		arm(1'b0);
		send_frame(8'h00, 0, 5);

		// Plain ACK with no reply to follow, trailer bytes ignored afterward.
		arm(1'b0);
		send_frame(ID_ACK, 1, WHOLE_FRAME);

		// Random traffic. Most of it is well-formed command/reply exchanges with
		// random content, some line noise ahead of the sync pair, and ACK
		// frames in front of the reply when one is expected. The rest is cut-off
		// frames and raw noise with random arming.
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				want_reply = 1'($urandom_range(0, 1));
				arm(want_reply);
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
				if (want_reply)
					send_frame(ID_ACK, 1, WHOLE_FRAME);
				roll = $urandom_range(0, 9);
				if (roll == 0)
					id = ID_NACK;
				else if (roll == 1)
					id = ID_ACK;
				else
					id = 8'($urandom);
				send_frame(id, pick_payload_size(), WHOLE_FRAME);
			end else if (pick < 90) begin
				arm(1'($urandom_range(0, 1)));
				send_frame(8'($urandom), $urandom_range(0, 12), $urandom_range(1, 8));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(1'($urandom_range(0, 1)), 8'($urandom),
						1'($urandom_range(0, 1)));
			end
		end
		s_tvalid <= 1'b0;

		// Drain: every predicted report must arrive, then a short quiet spell
		// shows whether anything extra comes out. The watchdog covers a hang.
		// The pending count is registered, so it is read from the edge after the
		// last input transaction, once that transaction has been predicted.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input transactions in %0d frames, with arming, noise and cut-offs.",
			items_sent, frames_sent);
		$display("Checked %0d reports against the prediction.", reports_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
